FILE: hw/rtl/efd_pkg.sv
// Shared constants and types for the escaped frame decoder.
// No dependencies; imported by every module of the block.
package efd_pkg;

  localparam int MAX_FRAME = 512;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);

  localparam logic [7:0] DELIM     = 8'hC0;
  localparam logic [7:0] ESC       = 8'hDB;
  localparam logic [7:0] ESC_DELIM = 8'hDC;
  localparam logic [7:0] ESC_ESC   = 8'hDD;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_command;
    logic       end_mark;
    logic       checksum_ok;
    logic       overflow;
  } efd_result_t;

endpackage

FILE: hw/rtl/efd_decode.sv
// Frame state and per-byte unescape / checksum logic.
// Depends on efd_pkg; result feeds efd_outbuf.
module efd_decode import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  output logic        res_valid,
  output efd_result_t res
);

  logic             esc_r,   esc_nxt;
  logic [7:0]       sum_r,   sum_nxt;
  logic             await_r, await_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic             ovf_r,   ovf_nxt;
  logic [7:0]       val;

  always_comb begin
    esc_nxt   = esc_r;
    sum_nxt   = sum_r;
    await_nxt = await_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    res_valid = 1'b0;
    res       = '0;
    val       = in_byte;
    if (esc_r && in_byte == ESC_DELIM) begin
      val = DELIM;
    end else if (esc_r && in_byte == ESC_ESC) begin
      val = ESC;
    end
    if (in_byte == DELIM) begin
      // close the frame; an empty one yields nothing
      res_valid       = !await_r || ovf_r;
      res.end_mark    = 1'b1;
      res.checksum_ok = (sum_r == SUM_GOOD);
      res.overflow    = ovf_r;
      esc_nxt   = 1'b0;
      sum_nxt   = '0;
      await_nxt = 1'b1;
      cnt_nxt   = '0;
      ovf_nxt   = 1'b0;
    end else if (cnt_r >= CNT_W'(MAX_FRAME)) begin
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (await_r) begin
        // command byte is taken raw
        await_nxt      = 1'b0;
        esc_nxt        = 1'b0;
        sum_nxt        = in_byte;
        res_valid      = 1'b1;
        res.data_byte  = in_byte;
        res.is_command = 1'b1;
      end else if (in_byte == ESC) begin
        esc_nxt = 1'b1;
      end else begin
        esc_nxt       = 1'b0;
        sum_nxt       = sum_r + val;
        res_valid     = 1'b1;
        res.data_byte = val;
      end
    end
    if (!accept) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r   <= 1'b0;
      sum_r   <= '0;
      await_r <= 1'b1;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      esc_r   <= esc_nxt;
      sum_r   <= sum_nxt;
      await_r <= await_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_delim_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_byte == DELIM) |=> (await_r && cnt_r == '0 && !ovf_r && !esc_r))
    else $error("delimiter did not return frame state to idle");

  a_count_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !await_r |-> cnt_r != '0)
    else $error("frame open with zero byte count");

endmodule

FILE: hw/rtl/efd_outbuf.sv
// Result register with one skid entry, so input stays open while a result waits.
// Depends on efd_pkg.
module efd_outbuf import efd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  efd_result_t res,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output efd_result_t out_res
);

  logic        out_valid_r;
  efd_result_t out_r;
  logic        skid_valid_r;
  efd_result_t skid_r;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // drain skid first, else take the new item
      out_valid_r  <= skid_valid_r || res_valid;
      skid_valid_r <= 1'b0;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (!out_free && res_valid) begin
      skid_r <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while output is empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !skid_valid_r)
    else $error("new result arrived while skid is full");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output");

endmodule

FILE: hw/rtl/escaped_frame_decoder_checksum.sv
// Escaped frame decoder with additive checksum: top level.
// A result is registered on out_* from its accepted input item, or held in the skid entry while out_stall is high.
// Throughput: one input item per cycle; the two-entry result buffer stalls input
// only while both entries are held, which happens only after a stalled output.
// Reset (rst_n low, synchronous) idles the frame state and empties the buffer.
// Depends on efd_pkg, efd_decode, efd_outbuf.
module escaped_frame_decoder_checksum import efd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_is_command,
  output logic       out_end_mark,
  output logic       out_checksum_ok,
  output logic       out_overflow
);

  logic        accept;
  logic        res_valid;
  efd_result_t res;
  logic        full;
  efd_result_t out_res;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  efd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  efd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_data_byte   = out_res.data_byte;
  assign out_is_command  = out_res.is_command;
  assign out_end_mark    = out_res.end_mark;
  assign out_checksum_ok = out_res.checksum_ok;
  assign out_overflow    = out_res.overflow;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench for escaped_frame_decoder_checksum: random and directed byte streams with
// random idling on both channels, checked against a cycle-free deframing predictor.
// Depends on efd_pkg and the decoder RTL.
module tb_top;
  import efd_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 600;

  // Tracks frame state as raw bytes are accepted and queues the decoded items due.
  class deframe_tracker;
    efd_result_t decoded_q[$];
    bit          esc_pending;
    bit          awaiting_cmd;
    bit          overflowed;
    logic [7:0]  sum;
    int unsigned raw_count;
    int          mismatches;
    int          dropped_bytes;

    function new();
      clear_frame();
      mismatches    = 0;
      dropped_bytes = 0;
    endfunction

    function void clear_frame();
      esc_pending  = 1'b0;
      awaiting_cmd = 1'b1;
      overflowed   = 1'b0;
      sum          = 8'h00;
      raw_count    = 0;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function void take_raw_byte(logic [7:0] b);
      efd_result_t r;
      logic [7:0]  v;
      r = '0;
      if (b == DELIM) begin
        if (!awaiting_cmd || overflowed) begin
          r.end_mark    = 1'b1;
          r.checksum_ok = (sum == SUM_GOOD);
          r.overflow    = overflowed;
          decoded_q.push_back(r);
        end
        clear_frame();
        return;
      end
      // Drop everything past the frame limit; only the delimiter still counts.
      if (raw_count >= MAX_FRAME) begin
        overflowed = 1'b1;
        dropped_bytes++;
        return;
      end
      raw_count++;
      if (awaiting_cmd) begin
        awaiting_cmd = 1'b0;
        esc_pending  = 1'b0;
        sum          = b;
        r.data_byte  = b;
        r.is_command = 1'b1;
        decoded_q.push_back(r);
        return;
      end
      if (b == ESC) begin
        esc_pending = 1'b1;
        return;
      end
      v = b;
      if (esc_pending) begin
        if (b == ESC_DELIM)
          v = DELIM;
        else if (b == ESC_ESC)
          v = ESC;
        esc_pending = 1'b0;
      end
      sum         = sum + v;
      r.data_byte = v;
      decoded_q.push_back(r);
    endfunction

    function void note_mismatch(string what, efd_result_t want, efd_result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"%0t mismatch (%s): expected data=%02h cmd=%0b end=%0b ok=%0b ovf=%0b,",
                  " got data=%02h cmd=%0b end=%0b ok=%0b ovf=%0b"},
                 $time, what, want.data_byte, want.is_command, want.end_mark,
                 want.checksum_ok, want.overflow, got.data_byte, got.is_command,
                 got.end_mark, got.checksum_ok, got.overflow);
    endfunction

    function void compare_decoded(efd_result_t got);
      efd_result_t want;
      if (decoded_q.size() == 0) begin
        note_mismatch("no item expected", '0, got);
        return;
      end
      want = decoded_q.pop_front();
      if (got.data_byte !== want.data_byte || got.is_command !== want.is_command ||
          got.end_mark !== want.end_mark || got.checksum_ok !== want.checksum_ok ||
          got.overflow !== want.overflow)
        note_mismatch("field", want, got);
    endfunction

    function void check_leftover();
      while (decoded_q.size() != 0)
        note_mismatch("item never arrived", decoded_q.pop_front(), '0);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_is_command;
  logic       out_end_mark;
  logic       out_checksum_ok;
  logic       out_overflow;

  deframe_tracker tracker;
  int             cycle_count;
  int             counted_items;

  escaped_frame_decoder_checksum uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_is_command  (out_is_command),
    .out_end_mark    (out_end_mark),
    .out_checksum_ok (out_checksum_ok),
    .out_overflow    (out_overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic logic [7:0] pick_value();
    logic [7:0] specials [6];
    specials = '{DELIM, ESC, ESC_DELIM, ESC_ESC, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0)
      return specials[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.compare_decoded({out_data_byte, out_is_command, out_end_mark,
                               out_checksum_ok, out_overflow});
  end

  // Receiver: runs of no stall, random toggling, and solid stall bursts.
  initial begin
    int r;
    int len;
    @(posedge rst_n);
    forever begin
      r   = $urandom_range(0, 99);
      len = (r < 40) ? $urandom_range(1, 40) : $urandom_range(1, 20);
      if (r >= 85)
        len = $urandom_range(2, 30);
      repeat (len) begin
        @(posedge clk);
        if (r < 40)
          out_stall <= 1'b0;
        else if (r < 85)
          out_stall <= 1'($urandom_range(0, 1));
        else
          out_stall <= 1'b1;
      end
    end
  end

  // Hold the item until accepted, then note it.
  task automatic send_raw(input logic [7:0] b, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_raw_byte(b);
  endtask

  task automatic send_frame(input bit calm);
    logic [7:0] raw[$];
    logic [7:0] partial;
    logic [7:0] v;
    int         n;
    int         kind;
    kind = $urandom_range(0, 99);
    if (kind >= 5 && kind < 15) begin
      // Noise: arbitrary bytes, stray delimiters included.
      n = $urandom_range(1, 20);
      repeat (n) raw.push_back(8'($urandom_range(0, 255)));
    end else if (kind >= 15) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      v = pick_value();
      while (v == DELIM) v = pick_value();
      raw.push_back(v);
      partial = v;
      for (int i = 0; i < n; i++) begin
        v = pick_value();
        // Close the sum to a good checksum about half the time.
        if (i == n - 1 && $urandom_range(0, 1) == 1)
          v = SUM_GOOD - partial;
        partial = partial + v;
        if (v == DELIM || v == ESC) begin
          if ($urandom_range(0, 7) == 0)
            raw.push_back(ESC);
          raw.push_back(ESC);
          raw.push_back(v == DELIM ? ESC_DELIM : ESC_ESC);
        end else if (v != ESC_DELIM && v != ESC_ESC && $urandom_range(0, 9) == 0) begin
          raw.push_back(ESC);
          raw.push_back(v);
        end else begin
          raw.push_back(v);
        end
      end
      if ($urandom_range(0, 19) == 0)
        raw.push_back(ESC);
    end
    raw.push_back(DELIM);
    counted_items += raw.size();
    foreach (raw[i]) send_raw(raw[i], calm);
  endtask

  task automatic send_long_frame(input int n_raw);
    logic [7:0] v;
    counted_items += n_raw + 1;
    for (int i = 0; i < n_raw; i++) begin
      v = pick_value();
      while (v == DELIM) v = pick_value();
      send_raw(v, $urandom_range(0, 3) != 0);
    end
    send_raw(DELIM, 1'b0);
  endtask

  initial begin
    logic [7:0] directed[$];
    int         long_done;
    tracker       = new();
    counted_items = 0;
    long_done     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty frames, raw escape as command, bare DC/DD, both escapes, repeated escape,
    // escaped ordinary byte, escape dropped at the delimiter, then a good checksum.
    directed = '{DELIM, DELIM,
                 ESC, ESC_DELIM, ESC_ESC, ESC, ESC_DELIM, ESC, ESC_ESC,
                 ESC, ESC, 8'h41, ESC, DELIM,
                 8'h00, 8'hFF, DELIM,
                 8'hFF, DELIM,
                 8'h80, 8'h7F, 8'h00, DELIM};
    counted_items += directed.size();
    foreach (directed[i]) send_raw(directed[i], 1'b0);

    while (counted_items < RANDOM_ITEMS) begin
      // One frame that runs past the length limit.
      if (long_done == 0 && counted_items >= 40) begin
        send_long_frame(MAX_FRAME + $urandom_range(1, 12));
        long_done++;
      end
      send_frame($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.check_leftover();
    if (tracker.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/efd_pkg.sv
hw/rtl/efd_decode.sv
hw/rtl/efd_outbuf.sv
hw/rtl/escaped_frame_decoder_checksum.sv
bench/tb_top.sv
